### rtl/u8k2h_pkg.sv
// Package for the UTF-8 katakana-to-hiragana converter.
// Holds the byte-class masks, the kana range and the output queue sizing.
// No dependencies.
package u8k2h_pkg;

    localparam int unsigned QueueDepth = 8;
    localparam int unsigned QueueAw    = $clog2(QueueDepth);
    localparam int unsigned MaxPush    = 3;

    // Lead byte classes.
    localparam logic [7:0] Mask1   = 8'h80;
    localparam logic [7:0] Mask2   = 8'hE0;
    localparam logic [7:0] Lead2   = 8'hC0;
    localparam logic [7:0] Mask3   = 8'hF0;
    localparam logic [7:0] Lead3   = 8'hE0;
    localparam logic [7:0] Mask4   = 8'hF8;
    localparam logic [7:0] Lead4   = 8'hF0;
    localparam logic [7:0] ContTag = 8'h80;

    // Group length codes.
    localparam logic [2:0] Size1 = 3'd1;
    localparam logic [2:0] Size2 = 3'd2;
    localparam logic [2:0] Size3 = 3'd3;
    localparam logic [2:0] Size4 = 3'd4;

    // Katakana block that is shifted down to hiragana.
    localparam logic [23:0] KanaLow   = 24'hE382A0;
    localparam logic [23:0] KanaHigh  = 24'hE383BF;
    localparam logic [15:0] KanaShift = 16'h0060;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    function automatic logic [2:0] group_size(input logic [7:0] lead);
        logic [2:0] size;
        size = Size1;
        if ((lead & Mask1) == 8'h00) begin
            size = Size1;
        end else if ((lead & Mask2) == Lead2) begin
            size = Size2;
        end else if ((lead & Mask3) == Lead3) begin
            size = Size3;
        end else if ((lead & Mask4) == Lead4) begin
            size = Size4;
        end
        return size;
    endfunction

endpackage

### rtl/utf8_katakana_to_hiragana.sv
// UTF-8 katakana-to-hiragana converter, top level.
// Uses u8k2h_pkg for byte classes, the kana range and queue sizing.

// Bytes are taken one per cycle while o_stall is low, and the state machine
// decides at the accept edge what each beat produces: 1- 2- and 4-byte groups
// pass through one beat per input beat, a 3-byte group is held and then
// written as three beats at once (converted from katakana to hiragana when it
// lies in U+30A0..U+30FF). Results are registered into an 8-entry output queue
// and read from its head; the queue drains one beat per cycle while i_stall is
// low, so the sustained rate is one byte per cycle when downstream does not
// stall. o_stall rises only when the queue has fewer than three free entries,
// which happens only when the downstream side stalls.
module utf8_katakana_to_hiragana (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    localparam int unsigned Aw = u8k2h_pkg::QueueAw;
    localparam int unsigned Cw = u8k2h_pkg::QueueAw + 1;

    // Group tracking state.
    logic [1:0] r_left, n_left;
    logic       r_hold, n_hold;
    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;

    // Output queue.
    u8k2h_pkg::t_beat r_queue [u8k2h_pkg::QueueDepth];
    logic [Aw-1:0]    r_wr_ptr;
    logic [Aw-1:0]    r_rd_ptr;
    logic [Cw-1:0]    r_count;

    logic             w_accept;
    logic             w_pop;
    logic [1:0]       w_push_cnt;
    u8k2h_pkg::t_beat w_push [u8k2h_pkg::MaxPush];
    logic [2:0]       w_size;
    logic [23:0]      w_group;
    logic [15:0]      w_cp;
    logic             w_kana;

    assign w_accept = i_valid && !o_stall;
    assign w_pop    = o_valid && !i_stall;
    assign o_valid  = (r_count != '0);
    assign o_stall  = (r_count > Cw'(u8k2h_pkg::QueueDepth - u8k2h_pkg::MaxPush));

    assign o_out_byte = r_queue[r_rd_ptr].data;
    assign o_out_last = r_queue[r_rd_ptr].last;

    assign w_size  = u8k2h_pkg::group_size(i_in_byte);
    assign w_group = {r_held0, r_held1, i_in_byte};
    assign w_kana  = (w_group >= u8k2h_pkg::KanaLow) && (w_group <= u8k2h_pkg::KanaHigh);
    assign w_cp    = {r_held0[3:0], r_held1[5:0], i_in_byte[5:0]} - u8k2h_pkg::KanaShift;

    always_comb begin
        n_left     = r_left;
        n_hold     = r_hold;
        n_held0    = r_held0;
        n_held1    = r_held1;
        w_push_cnt = 2'd0;
        for (int k = 0; k < u8k2h_pkg::MaxPush; k++) begin
            w_push[k] = '{data: i_in_byte, last: 1'b0};
        end
        if (r_left == 2'd0) begin
            if (w_size == u8k2h_pkg::Size3) begin
                if (i_in_last) begin
                    w_push_cnt = 2'd1;
                    w_push[0]  = '{data: i_in_byte, last: 1'b1};
                end else begin
                    n_held0 = i_in_byte;
                    n_left  = 2'd2;
                    n_hold  = 1'b1;
                end
            end else begin
                w_push_cnt = 2'd1;
                w_push[0]  = '{data: i_in_byte, last: i_in_last};
                if (!i_in_last && w_size != u8k2h_pkg::Size1) begin
                    n_left = 2'(w_size - 3'd1);
                    n_hold = 1'b0;
                end
            end
        end else if (!r_hold) begin
            w_push_cnt = 2'd1;
            w_push[0]  = '{data: i_in_byte, last: i_in_last};
            n_left     = i_in_last ? 2'd0 : r_left - 2'd1;
            n_hold     = 1'b0;
        end else if (r_left >= 2'd2) begin
            if (i_in_last) begin
                // Group cut short: flush what was held unchanged.
                w_push_cnt = 2'd2;
                w_push[0]  = '{data: r_held0, last: 1'b0};
                w_push[1]  = '{data: i_in_byte, last: 1'b1};
                n_left     = 2'd0;
                n_hold     = 1'b0;
            end else begin
                n_held1 = i_in_byte;
                n_left  = 2'd1;
            end
        end else begin
            w_push_cnt = 2'd3;
            n_left     = 2'd0;
            n_hold     = 1'b0;
            if (w_kana) begin
                w_push[0] = '{data: u8k2h_pkg::Lead3 | {4'h0, w_cp[15:12]}, last: 1'b0};
                w_push[1] = '{data: u8k2h_pkg::ContTag | {2'b00, w_cp[11:6]}, last: 1'b0};
                w_push[2] = '{data: u8k2h_pkg::ContTag | {2'b00, w_cp[5:0]},
                              last: i_in_last};
            end else begin
                w_push[0] = '{data: r_held0, last: 1'b0};
                w_push[1] = '{data: r_held1, last: 1'b0};
                w_push[2] = '{data: i_in_byte, last: i_in_last};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= 2'd0;
            r_hold   <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_accept) begin
                r_left   <= n_left;
                r_hold   <= n_hold;
                r_wr_ptr <= r_wr_ptr + Aw'(w_push_cnt);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + Aw'(1);
            end
            r_count <= r_count + (w_accept ? Cw'(w_push_cnt) : Cw'(0))
                               - (w_pop ? Cw'(1) : Cw'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            for (int k = 0; k < u8k2h_pkg::MaxPush; k++) begin
                if (2'(k) < w_push_cnt) begin
                    r_queue[r_wr_ptr + Aw'(k)] <= w_push[k];
                end
            end
        end
    end

    // The queue never overfills.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Cw'(u8k2h_pkg::QueueDepth))
        else $error("output queue overflow");

    // A held group always has bytes outstanding.
    a_hold_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold |-> (r_left != 2'd0))
        else $error("holding a group with nothing left");

    // An end marker always returns the tracker to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_last) |=> (r_left == 2'd0 && !r_hold))
        else $error("state not idle after end marker");

    // A beat that ends a string leaves something in the queue.
    a_last_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_last) |=> o_valid)
        else $error("end marker produced no output");

endmodule
